// ----- src/thick_line_quad_expander_top_assert.svh -----
// assertion macros used by the checker of the line expander
`ifndef THICK_LINE_QUAD_EXPANDER_TOP_ASSERT_SVH
`define THICK_LINE_QUAD_EXPANDER_TOP_ASSERT_SVH

// same-cycle implication
`define TLQE_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("tlqe assertion failed");

// next-cycle implication
`define TLQE_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("tlqe assertion failed");

`endif

// ----- src/tlqe_pkg.sv -----
`timescale 1ns / 1ps
package tlqe_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned WIDTH_W = 8;
  localparam int unsigned MITER_W = 12;
  localparam int unsigned MITER_SHIFT = 16;
  localparam int unsigned SQ_W = 33;
  localparam int unsigned ROOT_W = 25;
  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned LEN_FRAC = 16;
  localparam int unsigned MIN_ROOT_W = 8;
  localparam int unsigned LANES = 4;

  // divider lanes
  localparam int unsigned LANE_PERP_X = 0;
  localparam int unsigned LANE_PERP_Y = 1;
  localparam int unsigned LANE_EXT_X = 2;
  localparam int unsigned LANE_EXT_Y = 3;

  typedef logic [WIDTH_W-1:0] width_t;
  localparam width_t LINE_WIDTH_RESET = 8'd16;
  localparam logic [MITER_W-1:0] MITER_Q16 = 12'd3211;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } seg_t;

  typedef struct packed {
    coord_t corner0_x;
    coord_t corner0_y;
    coord_t corner1_x;
    coord_t corner1_y;
    coord_t corner2_x;
    coord_t corner2_y;
    coord_t corner3_x;
    coord_t corner3_y;
    color_t quad_color;
  } quad_t;

  // what rides along the pipe beside the arithmetic
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
    logic   neg_dx;
    logic   neg_dy;
  } seg_side_t;

  typedef struct packed {
    logic pipe_en;
    logic out_en;
  } stall_ctrl_t;

endpackage

// ----- src/tlqe_chan_if.sv -----
`timescale 1ns / 1ps
interface tlqe_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/tlqe_front.sv -----
`timescale 1ns / 1ps
module tlqe_front #(
  parameter int unsigned SHIFT = 7,
  parameter int unsigned NUM_W = 31,
  parameter int unsigned EXT_W = 43
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  tlqe_pkg::seg_t                  in_seg,
  input  tlqe_pkg::width_t                line_width,
  output logic                            out_valid,
  output logic [tlqe_pkg::SQ_W-1:0]       sq,
  output logic [NUM_W-1:0]                num_x,
  output logic [NUM_W-1:0]                num_y,
  output logic [EXT_W-1:0]                ext_x,
  output logic [EXT_W-1:0]                ext_y,
  output tlqe_pkg::seg_side_t             side
);
  localparam int unsigned CW = tlqe_pkg::COORD_W;
  localparam int unsigned MUL_W = tlqe_pkg::WIDTH_W + SHIFT;

  logic signed [CW:0]     dx_c;
  logic signed [CW:0]     dy_c;
  logic signed [CW:0]     adx_c;
  logic signed [CW:0]     ady_c;
  logic                   degen;
  logic [MUL_W-1:0]       mul_w;

  logic                   v0;
  tlqe_pkg::seg_side_t    side0;
  logic [CW-1:0]          adx0;
  logic [CW-1:0]          ady0;

  logic                   v1;
  tlqe_pkg::seg_side_t    side1;
  logic [2*CW-1:0]        sqx1;
  logic [2*CW-1:0]        sqy1;
  logic [NUM_W-1:0]       numx1;
  logic [NUM_W-1:0]       numy1;

  always_comb begin
    dx_c  = $signed({in_seg.end_x[CW-1], in_seg.end_x})
          - $signed({in_seg.start_x[CW-1], in_seg.start_x});
    dy_c  = $signed({in_seg.end_y[CW-1], in_seg.end_y})
          - $signed({in_seg.start_y[CW-1], in_seg.start_y});
    adx_c = dx_c[CW] ? -dx_c : dx_c;
    ady_c = dy_c[CW] ? -dy_c : dy_c;
    degen = (in_seg.start_x == in_seg.end_x) && (in_seg.start_y == in_seg.end_y);
    // half width in coordinate units, scaled by 2^8 for the q.8 length
    mul_w = MUL_W'(line_width) << SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid && !degen;
      v1        <= v0;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0.start_x    <= in_seg.start_x;
      side0.start_y    <= in_seg.start_y;
      side0.end_x      <= in_seg.end_x;
      side0.end_y      <= in_seg.end_y;
      side0.line_color <= in_seg.line_color;
      side0.neg_dx     <= dx_c[CW];
      side0.neg_dy     <= dy_c[CW];
      adx0             <= adx_c[CW-1:0];
      ady0             <= ady_c[CW-1:0];

      side1 <= side0;
      sqx1  <= (2*CW)'(adx0) * (2*CW)'(adx0);
      sqy1  <= (2*CW)'(ady0) * (2*CW)'(ady0);
      numx1 <= NUM_W'(adx0) * NUM_W'(mul_w);
      numy1 <= NUM_W'(ady0) * NUM_W'(mul_w);

      side  <= side1;
      sq    <= tlqe_pkg::SQ_W'(sqx1) + tlqe_pkg::SQ_W'(sqy1);
      num_x <= numx1;
      num_y <= numy1;
      ext_x <= EXT_W'(numx1) * EXT_W'(tlqe_pkg::MITER_Q16);
      ext_y <= EXT_W'(numy1) * EXT_W'(tlqe_pkg::MITER_Q16);
    end
  end
endmodule

// ----- src/tlqe_sqrt.sv -----
`timescale 1ns / 1ps
module tlqe_sqrt #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [tlqe_pkg::SQ_W-1:0]     rad_in,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          out_valid,
  output logic [tlqe_pkg::ROOT_W-1:0]   root,
  output logic [SIDE_W-1:0]             side_out
);
  localparam int unsigned RW = tlqe_pkg::ROOT_W;
  localparam int unsigned RAD_W = tlqe_pkg::RAD_W;
  localparam int unsigned REM_W = RW + 2;

  logic              v_q    [RW];
  logic [REM_W-1:0]  rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [RAD_W-1:0]  rad_q  [RW];
  logic [SIDE_W-1:0] side_q [RW];

  // one result bit per stage, two radicand bits consumed per stage
  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic              v_p;
    logic [REM_W-1:0]  rem_p;
    logic [RW-1:0]     root_p;
    logic [RAD_W-1:0]  rad_p;
    logic [SIDE_W-1:0] side_p;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = RAD_W'({rad_in, {tlqe_pkg::LEN_FRAC{1'b0}}});
      assign side_p = side_in;
    end else begin : g_next
      assign v_p    = v_q[i-1];
      assign rem_p  = rem_q[i-1];
      assign root_p = root_q[i-1];
      assign rad_p  = rad_q[i-1];
      assign side_p = side_q[i-1];
    end

    assign rem_sh = {rem_p, rad_p[RAD_W-1 -: 2]};
    assign trial  = (REM_W + 2)'({root_p, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_q[i] <= {root_p[RW-2:0], ge};
        rad_q[i]  <= rad_p << 2;
        side_q[i] <= side_p;
      end
    end
  end

  assign out_valid = v_q[RW-1];
  assign root      = root_q[RW-1];
  assign side_out  = side_q[RW-1];
endmodule

// ----- src/tlqe_div.sv -----
`timescale 1ns / 1ps
module tlqe_div #(
  parameter int unsigned NUM_W = 31,
  parameter int unsigned EXT_W = 43,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [tlqe_pkg::ROOT_W-1:0]       divisor,
  input  logic [NUM_W-1:0]                  num_x,
  input  logic [NUM_W-1:0]                  num_y,
  input  logic [EXT_W-1:0]                  ext_x,
  input  logic [EXT_W-1:0]                  ext_y,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              out_valid,
  output logic [NUM_W-tlqe_pkg::MIN_ROOT_W:0] quo [tlqe_pkg::LANES],
  output logic [SIDE_W-1:0]                 side_out
);
  localparam int unsigned RW = tlqe_pkg::ROOT_W;
  localparam int unsigned NL = tlqe_pkg::LANES;
  localparam int unsigned DIV_W = NUM_W + 1;
  localparam int unsigned QUO_W = DIV_W - tlqe_pkg::MIN_ROOT_W;
  localparam int unsigned REM_W = RW + 1;
  localparam int unsigned BIAS_W = EXT_W + 1;

  logic [BIAS_W-1:0] ext_bx;
  logic [BIAS_W-1:0] ext_by;

  logic              vb;
  logic [RW-1:0]     db;
  logic [DIV_W-1:0]  nb [NL];
  logic [SIDE_W-1:0] sb;

  logic              v_q    [QUO_W];
  logic [RW-1:0]     d_q    [QUO_W];
  logic [REM_W-1:0]  r_q    [QUO_W][NL];
  logic [QUO_W-1:0]  nq_q   [QUO_W][NL];
  logic [SIDE_W-1:0] side_q [QUO_W];

  // round to nearest: add half the divisor ahead of the truncating divide
  always_comb begin
    ext_bx = BIAS_W'(ext_x) + (BIAS_W'(divisor) << (tlqe_pkg::MITER_SHIFT - 1));
    ext_by = BIAS_W'(ext_y) + (BIAS_W'(divisor) << (tlqe_pkg::MITER_SHIFT - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      db <= divisor;
      sb <= side_in;
      nb[tlqe_pkg::LANE_PERP_X] <= DIV_W'(num_y) + DIV_W'(divisor >> 1);
      nb[tlqe_pkg::LANE_PERP_Y] <= DIV_W'(num_x) + DIV_W'(divisor >> 1);
      nb[tlqe_pkg::LANE_EXT_X]  <= DIV_W'(ext_bx >> tlqe_pkg::MITER_SHIFT);
      nb[tlqe_pkg::LANE_EXT_Y]  <= DIV_W'(ext_by >> tlqe_pkg::MITER_SHIFT);
    end
  end

  // restoring divide, one quotient bit per stage; divisor is at least 2^8
  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic              v_p;
    logic [RW-1:0]     d_p;
    logic [REM_W-1:0]  r_p  [NL];
    logic [QUO_W-1:0]  nq_p [NL];
    logic [SIDE_W-1:0] side_p;
    logic [REM_W-1:0]  r_n  [NL];
    logic [QUO_W-1:0]  nq_n [NL];

    if (j == 0) begin : g_first
      assign v_p    = vb;
      assign d_p    = db;
      assign side_p = sb;
      for (genvar k = 0; k < NL; k++) begin : g_lane
        assign r_p[k]  = REM_W'(nb[k][DIV_W-1:QUO_W]);
        assign nq_p[k] = nb[k][QUO_W-1:0];
      end
    end else begin : g_next
      assign v_p    = v_q[j-1];
      assign d_p    = d_q[j-1];
      assign side_p = side_q[j-1];
      for (genvar k = 0; k < NL; k++) begin : g_lane
        assign r_p[k]  = r_q[j-1][k];
        assign nq_p[k] = nq_q[j-1][k];
      end
    end

    always_comb begin
      logic [REM_W:0] t;
      logic           ge;
      for (int k = 0; k < NL; k++) begin
        t        = {r_p[k], nq_p[k][QUO_W-1]};
        ge       = t >= (REM_W + 1)'(d_p);
        r_n[k]   = ge ? REM_W'(t - (REM_W + 1)'(d_p)) : REM_W'(t);
        nq_n[k]  = {nq_p[k][QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_q[j]    <= d_p;
        side_q[j] <= side_p;
        for (int k = 0; k < NL; k++) begin
          r_q[j][k]  <= r_n[k];
          nq_q[j][k] <= nq_n[k];
        end
      end
    end
  end

  assign out_valid = v_q[QUO_W-1];
  assign side_out  = side_q[QUO_W-1];
  for (genvar k = 0; k < NL; k++) begin : g_out
    assign quo[k] = nq_q[QUO_W-1][k];
  end
endmodule

// ----- src/tlqe_back.sv -----
`timescale 1ns / 1ps
module tlqe_back #(
  parameter int unsigned QUO_W = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tlqe_pkg::stall_ctrl_t   ctrl,
  input  logic                    in_valid,
  input  logic [QUO_W-1:0]        quo [tlqe_pkg::LANES],
  input  tlqe_pkg::seg_side_t     side,
  output logic                    mid_valid,
  output logic                    out_valid,
  output tlqe_pkg::quad_t         quad
);
  localparam int unsigned CRD = tlqe_pkg::COORD_W;
  localparam int unsigned CW = QUO_W + 3;
  localparam logic signed [CW:0] MAX_C = (CW + 1)'(2 ** (CRD - 1) - 1);
  localparam logic signed [CW:0] MIN_C = -(CW + 1)'(2 ** (CRD - 1));

  logic signed [CW-1:0] q_s [tlqe_pkg::LANES];
  logic signed [CW-1:0] px_c, py_c, ox_c, oy_c;

  logic signed [CW-1:0] px, py, ax, ay, bx, by;
  tlqe_pkg::color_t     color_m;

  function automatic logic signed [CW-1:0] sext(input tlqe_pkg::coord_t c);
    sext = $signed({{(CW - CRD){c[CRD-1]}}, c});
  endfunction

  function automatic tlqe_pkg::coord_t sat(input logic signed [CW:0] v);
    logic signed [CW:0] lim;
    lim = v;
    if (v > MAX_C) begin
      lim = MAX_C;
    end else if (v < MIN_C) begin
      lim = MIN_C;
    end
    sat = tlqe_pkg::coord_t'(lim[CRD-1:0]);
  endfunction

  always_comb begin
    for (int k = 0; k < tlqe_pkg::LANES; k++) begin
      q_s[k] = $signed(CW'(quo[k]));
    end
    // perpendicular is (-dy, dx)
    px_c = side.neg_dy ? q_s[tlqe_pkg::LANE_PERP_X] : -q_s[tlqe_pkg::LANE_PERP_X];
    py_c = side.neg_dx ? -q_s[tlqe_pkg::LANE_PERP_Y] : q_s[tlqe_pkg::LANE_PERP_Y];
    ox_c = side.neg_dx ? -q_s[tlqe_pkg::LANE_EXT_X] : q_s[tlqe_pkg::LANE_EXT_X];
    oy_c = side.neg_dy ? -q_s[tlqe_pkg::LANE_EXT_Y] : q_s[tlqe_pkg::LANE_EXT_Y];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.pipe_en) begin
        mid_valid <= in_valid;
      end
      if (ctrl.out_en) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pipe_en) begin
      px      <= px_c;
      py      <= py_c;
      ax      <= sext(side.start_x) - ox_c;
      ay      <= sext(side.start_y) - oy_c;
      bx      <= sext(side.end_x) + ox_c;
      by      <= sext(side.end_y) + oy_c;
      color_m <= side.line_color;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      quad.corner0_x  <= sat((CW + 1)'(ax) + (CW + 1)'(px));
      quad.corner0_y  <= sat((CW + 1)'(ay) + (CW + 1)'(py));
      quad.corner1_x  <= sat((CW + 1)'(bx) + (CW + 1)'(px));
      quad.corner1_y  <= sat((CW + 1)'(by) + (CW + 1)'(py));
      quad.corner2_x  <= sat((CW + 1)'(bx) - (CW + 1)'(px));
      quad.corner2_y  <= sat((CW + 1)'(by) - (CW + 1)'(py));
      quad.corner3_x  <= sat((CW + 1)'(ax) - (CW + 1)'(px));
      quad.corner3_y  <= sat((CW + 1)'(ay) - (CW + 1)'(py));
      quad.quad_color <= color_m;
    end
  end
endmodule

// ----- src/thick_line_quad_expander_top.sv -----
`timescale 1ns / 1ps
// throughput: one item per cycle when the pipe is not stalled by a held output;
// each stage of the 25-step square root and of the four-lane restoring divider
// is registered, so a new item enters every cycle that the pipe is not stalled
// zero-length segments are dropped at the first stage and produce no result
// reset: clears all valid bits and loads line_width with 16 (1.0 px); no clearing pass
module thick_line_quad_expander_top #(
  parameter int unsigned COORD_FRAC_BITS = 4
) (
  input logic         clk,
  input logic         rst,
  tlqe_chan_if.sink   seg,
  tlqe_chan_if.source quad,
  tlqe_chan_if.sink   cfg
);
  localparam int unsigned SHIFT = COORD_FRAC_BITS + 3;
  localparam int unsigned MUL_W = tlqe_pkg::WIDTH_W + SHIFT;
  localparam int unsigned NUM_W = tlqe_pkg::COORD_W + MUL_W;
  localparam int unsigned EXT_W = NUM_W + tlqe_pkg::MITER_W;
  localparam int unsigned QUO_W = NUM_W + 1 - tlqe_pkg::MIN_ROOT_W;

  typedef struct packed {
    logic [NUM_W-1:0]    num_x;
    logic [NUM_W-1:0]    num_y;
    logic [EXT_W-1:0]    ext_x;
    logic [EXT_W-1:0]    ext_y;
    tlqe_pkg::seg_side_t seg;
  } root_side_t;

  localparam int unsigned ROOT_SIDE_W = $bits(root_side_t);
  localparam int unsigned SEG_SIDE_W = $bits(tlqe_pkg::seg_side_t);

  tlqe_pkg::width_t      line_width;
  tlqe_pkg::stall_ctrl_t ctrl;

  logic                           fr_valid;
  logic [tlqe_pkg::SQ_W-1:0]      fr_sq;
  root_side_t                     fr_side;

  logic                           rt_valid;
  logic [tlqe_pkg::ROOT_W-1:0]    rt_root;
  root_side_t                     rt_side;

  logic                           dv_valid;
  logic [QUO_W-1:0]               dv_quo [tlqe_pkg::LANES];
  tlqe_pkg::seg_side_t            dv_side;

  logic                           mid_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= tlqe_pkg::LINE_WIDTH_RESET;
    end else if (cfg.valid) begin
      line_width <= cfg.data;
    end
  end

  // output register decouples: the pipe keeps moving while a bubble sits ahead of it
  always_comb begin
    ctrl.out_en  = !quad.valid || quad.ready;
    ctrl.pipe_en = ctrl.out_en || !mid_valid;
  end

  assign seg.ready = ctrl.pipe_en;

  tlqe_front #(
    .SHIFT (SHIFT),
    .NUM_W (NUM_W),
    .EXT_W (EXT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (ctrl.pipe_en),
    .in_valid   (seg.valid),
    .in_seg     (seg.data),
    .line_width (line_width),
    .out_valid  (fr_valid),
    .sq         (fr_sq),
    .num_x      (fr_side.num_x),
    .num_y      (fr_side.num_y),
    .ext_x      (fr_side.ext_x),
    .ext_y      (fr_side.ext_y),
    .side       (fr_side.seg)
  );

  tlqe_sqrt #(
    .SIDE_W (ROOT_SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (ctrl.pipe_en),
    .in_valid  (fr_valid),
    .rad_in    (fr_sq),
    .side_in   (fr_side),
    .out_valid (rt_valid),
    .root      (rt_root),
    .side_out  (rt_side)
  );

  tlqe_div #(
    .NUM_W  (NUM_W),
    .EXT_W  (EXT_W),
    .SIDE_W (SEG_SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (ctrl.pipe_en),
    .in_valid  (rt_valid),
    .divisor   (rt_root),
    .num_x     (rt_side.num_x),
    .num_y     (rt_side.num_y),
    .ext_x     (rt_side.ext_x),
    .ext_y     (rt_side.ext_y),
    .side_in   (rt_side.seg),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .side_out  (dv_side)
  );

  tlqe_back #(
    .QUO_W (QUO_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_valid  (dv_valid),
    .quo       (dv_quo),
    .side      (dv_side),
    .mid_valid (mid_valid),
    .out_valid (quad.valid),
    .quad      (quad.data)
  );
endmodule

// ----- src/tlqe_checker.sv -----
`timescale 1ns / 1ps
`include "thick_line_quad_expander_top_assert.svh"
module tlqe_checker (
  input logic            clk,
  input logic            rst,
  input logic            seg_ready,
  input logic            quad_valid,
  input logic            quad_ready,
  input tlqe_pkg::quad_t quad_data
);
  localparam int unsigned CRD = tlqe_pkg::COORD_W;
  localparam tlqe_pkg::coord_t C_MAX = tlqe_pkg::coord_t'(2 ** (CRD - 1) - 1);
  localparam tlqe_pkg::coord_t C_MIN = tlqe_pkg::coord_t'(2 ** (CRD - 1));

  logic               unclipped;
  logic signed [CRD:0] d03x, d12x, d03y, d12y;

  always_comb begin
    unclipped = quad_data.corner0_x != C_MAX && quad_data.corner0_x != C_MIN
             && quad_data.corner0_y != C_MAX && quad_data.corner0_y != C_MIN
             && quad_data.corner1_x != C_MAX && quad_data.corner1_x != C_MIN
             && quad_data.corner1_y != C_MAX && quad_data.corner1_y != C_MIN
             && quad_data.corner2_x != C_MAX && quad_data.corner2_x != C_MIN
             && quad_data.corner2_y != C_MAX && quad_data.corner2_y != C_MIN
             && quad_data.corner3_x != C_MAX && quad_data.corner3_x != C_MIN
             && quad_data.corner3_y != C_MAX && quad_data.corner3_y != C_MIN;
    // both ends carry the same perpendicular offset
    d03x = (CRD + 1)'(quad_data.corner0_x) - (CRD + 1)'(quad_data.corner3_x);
    d12x = (CRD + 1)'(quad_data.corner1_x) - (CRD + 1)'(quad_data.corner2_x);
    d03y = (CRD + 1)'(quad_data.corner0_y) - (CRD + 1)'(quad_data.corner3_y);
    d12y = (CRD + 1)'(quad_data.corner1_y) - (CRD + 1)'(quad_data.corner2_y);
  end

  `TLQE_ASSERT_NEXT(a_stall_hold, clk, rst, quad_valid && !quad_ready, quad_valid && $stable(quad_data))
  `TLQE_ASSERT_IMPLY(a_no_block, clk, rst, !quad_valid || quad_ready, seg_ready)
  `TLQE_ASSERT_IMPLY(a_perp_x, clk, rst, quad_valid && unclipped, d03x == d12x)
  `TLQE_ASSERT_IMPLY(a_perp_y, clk, rst, quad_valid && unclipped, d03y == d12y)
endmodule

bind thick_line_quad_expander_top tlqe_checker u_tlqe_checker (
  .clk        (clk),
  .rst        (rst),
  .seg_ready  (seg.ready),
  .quad_valid (quad.valid),
  .quad_ready (quad.ready),
  .quad_data  (quad.data)
);
